// ===== hdl/button_debounce_long_press_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debouncer checker
// Clocked on clk; the reset-qualified forms are switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// implication in the same cycle, outside reset
`define BDLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle, outside reset
`define BDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication into the next cycle, also checked across reset
`define BDLP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long-press detection.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // timer and register widths
  localparam int TIMER_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int CFG_IDX_W  = 1;

  // stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int MODE_W      = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd40;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd3000;

  // button state machine
  typedef enum logic [MODE_W-1:0] {
    MODE_UP          = 3'd0,
    MODE_FALLING     = 3'd1,
    MODE_DOWN        = 3'd2,
    MODE_RAISING     = 3'd3,
    MODE_LONG_DOWN   = 3'd4,
    MODE_LONG_RAISING = 3'd5
  } mode_t;

  // transaction kinds
  typedef enum logic [IN_TUSER_W-1:0] {
    ACT_SAMPLE     = 2'd0,
    ACT_READ_SHORT = 2'd1,
    ACT_READ_LONG  = 2'd2
  } action_t;

  // timer control from the state machine
  typedef struct packed {
    logic tick;
    logic arm;
    logic check;
  } timer_ctl_t;

endpackage

// ===== hdl/bdlp_timer.sv =====
// ----------------------------------------------------------------------------
// bdlp_timer
// Saturating tick timer: armed, started by its first check, fires once the
// count has reached the duration.
// ----------------------------------------------------------------------------
module bdlp_timer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bdlp_pkg::timer_ctl_t        ctl,
  input  logic [bdlp_pkg::CFG_W-1:0]  duration,
  output logic                        fire
);
  import bdlp_pkg::*;

  logic [TIMER_BITS-1:0] count_r, count_nxt, count_tick;
  logic                  running_r, running_nxt;

  // advance on every sample while running, saturating
  assign count_tick = (ctl.tick && running_r && (count_r != '1)) ?
                      count_r + 1'b1 : count_r;

  // arm or check on top of the tick
  always_comb begin
    count_nxt   = count_tick;
    running_nxt = running_r;
    fire        = 1'b0;
    if (ctl.arm) begin
      count_nxt   = '0;
      running_nxt = 1'b0;
    end else if (ctl.check) begin
      if (!running_r) begin
        count_nxt   = '0;
        running_nxt = 1'b1;
      end else if (CMP_W'(count_tick) >= CMP_W'(duration)) begin
        running_nxt = 1'b0;
        fire        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      running_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

// ===== hdl/bdlp_core.sv =====
// ----------------------------------------------------------------------------
// bdlp_core
// Six-state button machine with two timers and the sticky press flags; works
// one transaction per enabled cycle.
// ----------------------------------------------------------------------------
module bdlp_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [bdlp_pkg::IN_TUSER_W-1:0]  action,
  input  logic                             button_level,
  input  logic [bdlp_pkg::CFG_W-1:0]       debounce_ticks,
  input  logic [bdlp_pkg::CFG_W-1:0]       long_press_ticks,
  output logic                             read_value,
  output logic [bdlp_pkg::MODE_W-1:0]      fsm_state
);
  import bdlp_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic       short_r, short_nxt;
  logic       long_r, long_nxt;
  logic       do_sample, do_read_short, do_read_long;
  timer_ctl_t db_ctl, hold_ctl;
  logic       db_fire, hold_fire;

  // decode the transaction kind
  always_comb begin
    do_sample     = 1'b0;
    do_read_short = 1'b0;
    do_read_long  = 1'b0;
    case (action_t'(action))
      ACT_SAMPLE:     do_sample     = step;
      ACT_READ_SHORT: do_read_short = step;
      ACT_READ_LONG:  do_read_long  = step;
      default:        ;
    endcase
  end

  // timer controls
  always_comb begin
    db_ctl         = '0;
    hold_ctl       = '0;
    db_ctl.tick    = do_sample;
    hold_ctl.tick  = do_sample;
    if (do_sample) begin
      case (mode_r)
        MODE_UP:           db_ctl.arm   = button_level;
        MODE_FALLING:      db_ctl.check = button_level;
        MODE_DOWN: begin
          db_ctl.arm     = !button_level;
          hold_ctl.check = 1'b1;
        end
        MODE_RAISING:      db_ctl.check = !button_level;
        MODE_LONG_DOWN:    db_ctl.arm   = !button_level;
        MODE_LONG_RAISING: db_ctl.check = !button_level;
        default:           ;
      endcase
      // confirmed press arms the hold timer
      if (mode_r == MODE_FALLING && button_level && db_fire) begin
        hold_ctl.arm = 1'b1;
      end
    end
  end

  bdlp_timer u_db_timer (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (db_ctl),
    .duration (debounce_ticks),
    .fire     (db_fire)
  );

  bdlp_timer u_hold_timer (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hold_ctl),
    .duration (long_press_ticks),
    .fire     (hold_fire)
  );

  // next state and sticky flags
  always_comb begin
    mode_nxt  = mode_r;
    short_nxt = short_r && !do_read_short;
    long_nxt  = long_r && !do_read_long;
    if (do_sample) begin
      case (mode_r)
        MODE_UP: begin
          if (button_level) mode_nxt = MODE_FALLING;
        end
        MODE_FALLING: begin
          if (!button_level) mode_nxt = MODE_UP;
          else if (db_fire)  mode_nxt = MODE_DOWN;
        end
        MODE_DOWN: begin
          // long press wins over a release seen on the same tick
          if (hold_fire) begin
            mode_nxt = MODE_LONG_DOWN;
            long_nxt = 1'b1;
          end else if (!button_level) begin
            mode_nxt = MODE_RAISING;
          end
        end
        MODE_RAISING: begin
          if (button_level) begin
            mode_nxt = MODE_DOWN;
          end else if (db_fire) begin
            mode_nxt  = MODE_UP;
            short_nxt = 1'b1;
          end
        end
        MODE_LONG_DOWN: begin
          if (!button_level) mode_nxt = MODE_LONG_RAISING;
        end
        MODE_LONG_RAISING: begin
          if (button_level) mode_nxt = MODE_LONG_DOWN;
          else if (db_fire) mode_nxt = MODE_UP;
        end
        default: mode_nxt = MODE_UP;
      endcase
    end
  end

  // result of this transaction
  always_comb begin
    read_value = (do_read_short && short_r) || (do_read_long && long_r);
    fsm_state  = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_UP;
      short_r <= 1'b0;
      long_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      short_r <= short_nxt;
      long_r  <= long_nxt;
    end
  end

endmodule

// ===== hdl/button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Push-button debouncer with long-press detection and read-and-clear flags.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)               | tuser
//  in_     | input     | button_level, 7 unused bits      | action
//  out_    | output    | read_value, fsm_state, 4 zeros   | -
//  cfg_    | input     | cfg_data: 16-bit register value  | -
//
// One transaction per cycle while the output is not stalled; each accepted
// transaction passes the input register, then the result register.
// Reset (rst_n low, synchronous) clears the state machine, both timers, the
// flags, the pipeline valids and loads the register defaults.
// A stalled output holds its result; the input register keeps accepting while
// it can move forward, so in_tready falls only when both stages are full.
// ----------------------------------------------------------------------------
module button_debounce_long_press (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bdlp_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] button_level
  input  logic [bdlp_pkg::IN_TUSER_W-1:0]    in_tuser,   // [1:0] action
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bdlp_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [0] read_value, [3:1] fsm_state
  // configuration writes
  input  logic                               cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]         cfg_data
);
  import bdlp_pkg::*;

  logic                   stg_valid_r;
  logic [IN_TUSER_W-1:0]  stg_action_r;
  logic                   stg_level_r;
  logic                   out_valid_r;
  logic                   out_read_r;
  logic [MODE_W-1:0]      out_state_r;
  logic [CFG_W-1:0]       debounce_ticks_r, long_press_ticks_r;
  logic                   advance, step;
  logic                   core_read;
  logic [MODE_W-1:0]      core_state;

  // pipeline flow
  assign advance   = !out_valid_r || out_tready;
  assign step      = stg_valid_r && advance;
  assign in_tready = !stg_valid_r || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= DEBOUNCE_RST;
      long_press_ticks_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ticks_r   <= cfg_data;
        REG_LONG_PRESS: long_press_ticks_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_action_r <= in_tuser;
      stg_level_r  <= in_tdata[0];
    end
  end

  bdlp_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .action           (stg_action_r),
    .button_level     (stg_level_r),
    .debounce_ticks   (debounce_ticks_r),
    .long_press_ticks (long_press_ticks_r),
    .read_value       (core_read),
    .fsm_state        (core_state)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_read_r  <= core_read;
      out_state_r <= core_state;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - MODE_W - 1){1'b0}}, out_state_r, out_read_r};

endmodule

// ===== hdl/bdlp_checker.sv =====
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks on the debouncer result stream.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_assert.svh"

module bdlp_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [bdlp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bdlp_pkg::*;

  logic              out_fire;
  logic [MODE_W-1:0] cur_mode;
  logic [MODE_W-1:0] prev_mode_r;
  logic              prev_seen_r;

  assign out_fire = out_tvalid && out_tready;
  assign cur_mode = out_tdata[MODE_W:1];

  // state carried by the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seen_r <= 1'b0;
      prev_mode_r <= MODE_UP;
    end else if (out_fire) begin
      prev_seen_r <= 1'b1;
      prev_mode_r <= cur_mode;
    end
  end

  // a stalled result stays offered and unchanged
  `BDLP_ASSERT_NEXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `BDLP_ASSERT_NEXT(a_hold_data, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")

  // nothing is offered right after reset
  `BDLP_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid, "result offered after reset")

  // from button up only a press start may follow
  `BDLP_ASSERT_NOW(a_up_next, out_fire && prev_seen_r && prev_mode_r == MODE_UP, cur_mode == MODE_UP || cur_mode == MODE_FALLING, "illegal step out of button up")

  // a long press never returns to the short-press states
  `BDLP_ASSERT_NOW(a_long_next, out_fire && prev_seen_r && prev_mode_r == MODE_LONG_DOWN, cur_mode == MODE_LONG_DOWN || cur_mode == MODE_LONG_RAISING, "illegal step out of long down")

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);
